/* src/bavg_pkg.sv */
// Package for the bitmap and attribute video generator.
// Holds the action codes, screen geometry constants and the render stage type.
// No dependencies.
`timescale 1ns / 1ps

package bavg_pkg;

  typedef enum logic [1:0] {
    ACT_MEM_WRITE = 2'd0,
    ACT_RENDER    = 2'd1,
    ACT_FRAME_END = 2'd2,
    ACT_BORDER    = 2'd3
  } action_t;

  localparam int BORDER_GROUPS = 4;
  localparam int CELL_GROUPS   = 32;
  localparam int SCREEN_LINES  = 192;

  localparam int BITMAP_DEPTH  = 6144;
  localparam int ATTR_DEPTH    = 768;
  localparam int BITMAP_AW     = $clog2(BITMAP_DEPTH);
  localparam int ATTR_AW       = $clog2(ATTR_DEPTH);

  // Processor window: 0x4000 up to 0x5AFF, attributes start 0x1800 into it.
  localparam logic [15:0] WINDOW_BASE = 16'h4000;
  localparam logic [15:0] WINDOW_END  = 16'h5B00;

  localparam logic [BITMAP_AW-1:0] CLEAR_LAST = BITMAP_AW'(BITMAP_DEPTH - 1);

  // Control that travels with a render transaction from the read stage to the
  // output register, alongside the registered memory read data.
  typedef struct packed {
    logic       valid;
    logic       is_border;
    logic [2:0] border;
    logic       flash_on;
  } render_ctrl_t;

endpackage

/* src/bitmap_attribute_video_generator_core.sv */
// Top level of the bitmap and attribute video generator.
// Holds the screen memories, the clearing pass, the render pipeline and the handshakes.
// Depends on bavg_pkg.
`timescale 1ns / 1ps

// The generator holds a 6144-byte bitmap memory and a 768-byte attribute memory,
// together the 6912-byte screen image that the processor sees at 0x4000 to 0x5AFF.
// One input transaction is taken per clock cycle while item_ready is high: a
// memory write, a render request, an end-of-frame tick or a border colour write.
// Only a render request produces an output transaction, eight 4-bit colour
// indices with bit 3 as bright, and it passes through the synchronous memory
// read and then the output register. Both memories read and write in the same
// cycle; a write is committed at the edge that accepts it, so a later render
// always sees it and no forwarding is required. Throughput is one transaction per
// cycle as long as results are taken; a stalled output holds one result in the
// output register and one in the read stage, after which item_ready drops.
// After reset the memories are cleared one bitmap entry (and, in parallel, one
// attribute entry) per cycle; item_ready stays low during that pass.
module bitmap_attribute_video_generator_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_ready,
  input  logic [1:0] action,
  input  logic [15:0] address,
  input  logic [7:0] data,
  input  logic [7:0] line,
  input  logic [5:0] column_group,
  output logic       result_valid,
  input  logic       result_ready,
  output logic [3:0] pixel_0,
  output logic [3:0] pixel_1,
  output logic [3:0] pixel_2,
  output logic [3:0] pixel_3,
  output logic [3:0] pixel_4,
  output logic [3:0] pixel_5,
  output logic [3:0] pixel_6,
  output logic [3:0] pixel_7
);

  localparam int BAW = bavg_pkg::BITMAP_AW;
  localparam int AAW = bavg_pkg::ATTR_AW;

  // Screen memories.
  logic [7:0] bitmap_mem [bavg_pkg::BITMAP_DEPTH];
  logic [7:0] attr_mem   [bavg_pkg::ATTR_DEPTH];
  logic [7:0] bitmap_rd;
  logic [7:0] attr_rd;

  // Small state.
  logic [2:0]     border_colour;
  logic [4:0]     flash_count;
  logic           clearing;
  logic [BAW-1:0] clear_addr;

  // Read stage and output register.
  bavg_pkg::render_ctrl_t s1;
  logic [3:0] pix_q [8];

  logic in_accept;
  logic s1_advance;
  bavg_pkg::action_t act;

  assign act = bavg_pkg::action_t'(action);

  // The read stage moves on when the output register is empty or being emptied.
  assign s1_advance = !result_valid || result_ready;
  assign item_ready = !clearing && (!s1.valid || s1_advance);
  assign in_accept  = item_valid && item_ready;

  // Render address generation. The bitmap is interleaved by thirds, character
  // rows and pixel rows; the attribute row follows the character row.
  logic           is_border;
  logic [4:0]     cell_index;
  logic [BAW-1:0] bitmap_raddr;
  logic [AAW-1:0] attr_raddr;
  logic           render_rd;

  always_comb begin
    is_border = (line >= 8'(bavg_pkg::SCREEN_LINES))
             || (column_group < 6'(bavg_pkg::BORDER_GROUPS))
             || (column_group >= 6'(bavg_pkg::BORDER_GROUPS + bavg_pkg::CELL_GROUPS));
    cell_index = 5'(column_group - 6'(bavg_pkg::BORDER_GROUPS));
    bitmap_raddr = {line[7:6], line[2:0], line[5:3], cell_index};
    attr_raddr = {line[7:3], cell_index};
    render_rd = in_accept && (act == bavg_pkg::ACT_RENDER) && !is_border;
  end

  // Processor write decode: the window splits into bitmap and attribute parts.
  logic [15:0]    offset;
  logic           in_window;
  logic           cpu_bitmap_we;
  logic           cpu_attr_we;

  always_comb begin
    offset = address - bavg_pkg::WINDOW_BASE;
    in_window = (address >= bavg_pkg::WINDOW_BASE) && (address < bavg_pkg::WINDOW_END);
    cpu_bitmap_we = in_accept && (act == bavg_pkg::ACT_MEM_WRITE) && in_window
                 && (offset[12:11] != 2'b11);
    cpu_attr_we = in_accept && (act == bavg_pkg::ACT_MEM_WRITE) && in_window
               && (offset[12:11] == 2'b11);
  end

  // Memory write ports are shared between the clearing pass and the processor;
  // the two never overlap because no transaction is accepted while clearing.
  logic           bitmap_we;
  logic [BAW-1:0] bitmap_waddr;
  logic [7:0]     bitmap_wdata;
  logic           attr_we;
  logic [AAW-1:0] attr_waddr;
  logic [7:0]     attr_wdata;

  always_comb begin
    if (clearing) begin
      bitmap_we    = 1'b1;
      bitmap_waddr = clear_addr;
      bitmap_wdata = 8'h00;
      attr_we      = (clear_addr < BAW'(bavg_pkg::ATTR_DEPTH));
      attr_waddr   = clear_addr[AAW-1:0];
      attr_wdata   = 8'h00;
    end else begin
      bitmap_we    = cpu_bitmap_we;
      bitmap_waddr = offset[BAW-1:0];
      bitmap_wdata = data;
      attr_we      = cpu_attr_we;
      attr_waddr   = offset[AAW-1:0];
      attr_wdata   = data;
    end
  end

  always_ff @(posedge clk) begin
    if (bitmap_we) begin
      bitmap_mem[bitmap_waddr] <= bitmap_wdata;
    end
    if (render_rd) begin
      bitmap_rd <= bitmap_mem[bitmap_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (attr_we) begin
      attr_mem[attr_waddr] <= attr_wdata;
    end
    if (render_rd) begin
      attr_rd <= attr_mem[attr_raddr];
    end
  end

  // Clearing pass, border colour and flash counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing      <= 1'b1;
      clear_addr    <= '0;
      border_colour <= 3'd0;
      flash_count   <= 5'd0;
    end else begin
      if (clearing) begin
        clear_addr <= clear_addr + 1'b1;
        if (clear_addr == bavg_pkg::CLEAR_LAST) begin
          clearing <= 1'b0;
        end
      end
      if (in_accept && (act == bavg_pkg::ACT_BORDER)) begin
        border_colour <= data[2:0];
      end
      if (in_accept && (act == bavg_pkg::ACT_FRAME_END)) begin
        flash_count <= flash_count + 1'b1;
      end
    end
  end

  // Read stage: the border colour and flash phase are captured with the
  // request so that later transactions cannot change a render in flight.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid <= 1'b0;
    end else if (in_accept || s1_advance) begin
      s1.valid <= in_accept && (act == bavg_pkg::ACT_RENDER);
    end
    if (in_accept) begin
      s1.is_border <= is_border;
      s1.border    <= border_colour;
      s1.flash_on  <= !flash_count[4];
    end
  end

  // Colour selection from the attribute byte: ink in bits 2..0, paper in
  // bits 5..3, bright in bit 6, flash in bit 7.
  logic [3:0] ink;
  logic [3:0] paper;
  logic [3:0] fg;
  logic [3:0] bg;
  logic [3:0] pix_d [8];

  always_comb begin
    ink   = {attr_rd[6], attr_rd[2:0]};
    paper = {attr_rd[6], attr_rd[5:3]};
    if (attr_rd[7] && s1.flash_on) begin
      fg = paper;
      bg = ink;
    end else begin
      fg = ink;
      bg = paper;
    end
    for (int k = 0; k < 8; k++) begin
      if (s1.is_border) begin
        pix_d[k] = {1'b0, s1.border};
      end else begin
        pix_d[k] = bitmap_rd[7-k] ? fg : bg;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_advance) begin
      result_valid <= s1.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance && s1.valid) begin
      for (int k = 0; k < 8; k++) begin
        pix_q[k] <= pix_d[k];
      end
    end
  end

  assign pixel_0 = pix_q[0];
  assign pixel_1 = pix_q[1];
  assign pixel_2 = pix_q[2];
  assign pixel_3 = pix_q[3];
  assign pixel_4 = pix_q[4];
  assign pixel_5 = pix_q[5];
  assign pixel_6 = pix_q[6];
  assign pixel_7 = pix_q[7];

  // No transaction may be taken while the memories are being cleared.
  assert property (@(posedge clk) clearing |-> !item_ready)
    else $error("transaction accepted during clearing pass");

  // Nothing is in flight during the clearing pass.
  assert property (@(posedge clk) disable iff (rst) clearing |-> !s1.valid && !result_valid)
    else $error("pipeline busy during clearing pass");

  // An accepted render occupies the read stage in the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    in_accept && (act == bavg_pkg::ACT_RENDER) |=> s1.valid)
    else $error("render transaction lost before read stage");

  // A render in the read stage that can advance reaches the output register.
  assert property (@(posedge clk) disable iff (rst)
    s1.valid && s1_advance |=> result_valid)
    else $error("render transaction lost before output");

  // Memory reads are never issued for out-of-range addresses.
  assert property (@(posedge clk) disable iff (rst)
    render_rd |-> (bitmap_raddr < BAW'(bavg_pkg::BITMAP_DEPTH))
               && (attr_raddr < AAW'(bavg_pkg::ATTR_DEPTH)))
    else $error("screen memory read out of range");

endmodule

/* tb/testbench.sv */
// Self-checking testbench for bitmap_attribute_video_generator_core.
// A scoreboard class keeps its own copy of the screen store, border colour and flash
// counter, predicts every rendered group and checks it. Depends on bavg_pkg and the RTL.
`timescale 1ns / 1ps

module testbench;

  localparam int STORE_BYTES    = bavg_pkg::BITMAP_DEPTH + bavg_pkg::ATTR_DEPTH;
  localparam int HOLD_CYCLES    = 400;
  // The limit must also cover the clearing pass after reset, which keeps the input closed.
  localparam int QUIET_LIMIT    = 20000;
  localparam int PHASE_ITEMS    = 280;
  localparam int PRESSURE_ITEMS = 40;

  // Element k holds pixel_k, so pixel_0 sits in the low nibble.
  typedef logic [7:0][3:0] colour_group_t;

  typedef struct {
    logic [7:0]    line;
    logic [5:0]    group;
    colour_group_t pixels;
  } pending_group_t;

  class frame_scoreboard;
    logic [7:0]     screen[STORE_BYTES];
    logic [2:0]     border_colour;
    logic [4:0]     flash_count;
    pending_group_t expected_groups[$];
    int             errors;

    function new();
      foreach (screen[i]) screen[i] = 8'h00;
      border_colour = 3'd0;
      flash_count   = 5'd0;
      errors        = 0;
    endfunction

    // Bitmap rows are interleaved: thirds of the screen, then pixel row within
    // the character, then character row within the third.
    static function int bitmap_offset(int ln, int cell_index);
      return ((ln & 'hC0) << 5) + ((ln & 'h07) << 8) + ((ln & 'h38) << 2) + cell_index;
    endfunction

    static function int attr_offset(int ln, int cell_index);
      return bavg_pkg::BITMAP_DEPTH + 32 * (ln >> 3) + cell_index;
    endfunction

    function colour_group_t render(logic [7:0] ln, logic [5:0] grp);
      colour_group_t g;
      int            cell_index;
      int            k;
      logic [7:0]    bits;
      logic [7:0]    attr;
      logic [3:0]    ink;
      logic [3:0]    paper;
      logic [3:0]    swap;
      if (ln >= bavg_pkg::SCREEN_LINES || grp < bavg_pkg::BORDER_GROUPS ||
          grp >= bavg_pkg::BORDER_GROUPS + bavg_pkg::CELL_GROUPS) begin
        // Border groups, groups past the right border and lines below the
        // picture all show the border colour without bright.
        for (k = 0; k < 8; k++) g[k] = {1'b0, border_colour};
        return g;
      end
      cell_index = int'(grp) - bavg_pkg::BORDER_GROUPS;
      bits  = screen[bitmap_offset(ln, cell_index)];
      attr  = screen[attr_offset(ln, cell_index)];
      ink   = {attr[6], attr[2:0]};
      paper = {attr[6], attr[5:3]};
      if (attr[7] && flash_count < 5'd16) begin
        swap  = ink;
        ink   = paper;
        paper = swap;
      end
      for (k = 0; k < 8; k++) g[k] = bits[7 - k] ? ink : paper;
      return g;
    endfunction

    function void note_item(bavg_pkg::action_t act, logic [15:0] a, logic [7:0] d,
                            logic [7:0] ln, logic [5:0] grp);
      pending_group_t p;
      case (act)
        bavg_pkg::ACT_MEM_WRITE: begin
          if (a >= bavg_pkg::WINDOW_BASE && a < bavg_pkg::WINDOW_END)
            screen[int'(a - bavg_pkg::WINDOW_BASE)] = d;
        end
        bavg_pkg::ACT_RENDER: begin
          p.line   = ln;
          p.group  = grp;
          p.pixels = render(ln, grp);
          expected_groups.push_back(p);
        end
        bavg_pkg::ACT_FRAME_END: flash_count = flash_count + 5'd1;
        bavg_pkg::ACT_BORDER:    border_colour = d[2:0];
      endcase
    endfunction

    function void check_group(colour_group_t got);
      pending_group_t want;
      int             k;
      if (expected_groups.size() == 0) begin
        errors++;
        $display("%0t: result %h arrived with nothing expected", $time, got);
        return;
      end
      want = expected_groups.pop_front();
      for (k = 0; k < 8; k++) begin
        if (got[k] !== want.pixels[k]) begin
          errors++;
          $display("%0t: line %0d group %0d pixel_%0d expected %h, got %h",
                   $time, want.line, want.group, k, want.pixels[k], got[k]);
        end
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        item_valid;
  logic        item_ready;
  logic [1:0]  action;
  logic [15:0] address;
  logic [7:0]  data;
  logic [7:0]  line;
  logic [5:0]  column_group;
  logic        result_valid;
  logic        result_ready;
  logic [3:0]  pixel_0;
  logic [3:0]  pixel_1;
  logic [3:0]  pixel_2;
  logic [3:0]  pixel_3;
  logic [3:0]  pixel_4;
  logic [3:0]  pixel_5;
  logic [3:0]  pixel_6;
  logic [3:0]  pixel_7;

  frame_scoreboard sb;

  // Percentages of cycles in which the sender idles and the receiver stalls.
  int idle_pct;
  int stall_pct;
  // The stimulus raises a request; the receiver process serves it by holding off.
  int holds_requested;
  int holds_done;

  // Recently written cells, so that renders revisit content that was just stored.
  int recent_line[8];
  int recent_cell[8];
  int recent_pos;

  bitmap_attribute_video_generator_core dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .action       (action),
    .address      (address),
    .data         (data),
    .line         (line),
    .column_group (column_group),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .pixel_0      (pixel_0),
    .pixel_1      (pixel_1),
    .pixel_2      (pixel_2),
    .pixel_3      (pixel_3),
    .pixel_4      (pixel_4),
    .pixel_5      (pixel_5),
    .pixel_6      (pixel_6),
    .pixel_7      (pixel_7)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Both channels are sampled at the rising edge. A render accepted at one edge
  // must pass the read stage and the output register before it can come back, so
  // the order of the two calls within one edge does not matter.
  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid && result_ready)
        sb.check_group({pixel_7, pixel_6, pixel_5, pixel_4,
                        pixel_3, pixel_2, pixel_1, pixel_0});
      if (item_valid && item_ready)
        sb.note_item(bavg_pkg::action_t'(action), address, data, line, column_group);
    end
  end

  // Watchdog: the run ends if no transaction moves on either side for too long.
  always @(posedge clk) begin
    int quiet_cycles;
    if ((item_valid && item_ready) || (result_valid && result_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
      $display("** bitmap_attribute_video_generator_core: FAILED **");
      $finish;
    end
  end

  // Result side. A pending hold keeps ready low for a long counted stretch so
  // that the pipeline fills and the block has to close its input.
  initial begin
    result_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (holds_done != holds_requested) begin
        result_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        holds_done++;
      end else begin
        result_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Offers one transaction. Idle cycles come first, so valid only ever drops
  // between transactions and never while one is on offer.
  task automatic offer_item(bavg_pkg::action_t act, logic [15:0] a, logic [7:0] d,
                            logic [7:0] ln, logic [5:0] grp);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid   <= 1'b1;
    action       <= act;
    address      <= a;
    data         <= d;
    line         <= ln;
    column_group <= grp;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
  endtask

  // Mostly well-formed traffic: writes that land on real bitmap and attribute
  // bytes, renders of the cells just written, plus stray addresses and groups.
  task automatic offer_random_item();
    int          pick;
    int          sel;
    int          ln;
    int          cell_index;
    int          k;
    logic [15:0] a;
    logic [7:0]  rline;
    logic [5:0]  rgrp;
    pick = $urandom_range(99);
    sel  = $urandom_range(99);
    if (pick < 38) begin
      ln         = $urandom_range(bavg_pkg::SCREEN_LINES - 1);
      cell_index = $urandom_range(bavg_pkg::CELL_GROUPS - 1);
      if (sel < 45)
        a = bavg_pkg::WINDOW_BASE + 16'(frame_scoreboard::bitmap_offset(ln, cell_index));
      else if (sel < 75)
        a = bavg_pkg::WINDOW_BASE + 16'(frame_scoreboard::attr_offset(ln, cell_index));
      else if (sel < 90)
        a = bavg_pkg::WINDOW_BASE + 16'($urandom_range(STORE_BYTES - 1));
      else
        a = 16'($urandom_range(16'hFFFF));
      if (sel < 75) begin
        recent_line[recent_pos] = ln;
        recent_cell[recent_pos] = cell_index;
        recent_pos = (recent_pos + 1) % 8;
      end
      offer_item(bavg_pkg::ACT_MEM_WRITE, a, 8'($urandom_range(255)),
                 8'($urandom_range(255)), 6'($urandom_range(63)));
    end else if (pick < 80) begin
      if (sel < 60) begin
        k     = $urandom_range(7);
        rline = 8'(recent_line[k]);
        rgrp  = 6'(recent_cell[k] + bavg_pkg::BORDER_GROUPS);
      end else begin
        rline = ($urandom_range(99) < 85)
                ? 8'($urandom_range(bavg_pkg::SCREEN_LINES - 1))
                : 8'($urandom_range(255));
        rgrp  = ($urandom_range(99) < 80) ? 6'($urandom_range(39))
                                          : 6'($urandom_range(63));
      end
      offer_item(bavg_pkg::ACT_RENDER, 16'($urandom_range(16'hFFFF)),
                 8'($urandom_range(255)), rline, rgrp);
    end else if (pick < 92) begin
      offer_item(bavg_pkg::ACT_FRAME_END, 16'($urandom_range(16'hFFFF)),
                 8'($urandom_range(255)), 8'($urandom_range(255)),
                 6'($urandom_range(63)));
    end else begin
      offer_item(bavg_pkg::ACT_BORDER, 16'($urandom_range(16'hFFFF)),
                 8'($urandom_range(255)), 8'($urandom_range(255)),
                 6'($urandom_range(63)));
    end
  endtask

  initial begin
    int idle_set[4];
    int stall_set[4];
    int phase;
    int n;
    idle_set  = '{0, 56, 0, 30};
    stall_set = '{0, 0, 56, 30};
    sb = new();
    rst             = 1'b1;
    item_valid      = 1'b0;
    action          = bavg_pkg::ACT_MEM_WRITE;
    address         = 16'h0000;
    data            = 8'h00;
    line            = 8'h00;
    column_group    = 6'd0;
    idle_pct        = 0;
    stall_pct       = 0;
    holds_requested = 0;
    holds_done      = 0;
    recent_pos      = 0;
    foreach (recent_line[i]) begin
      recent_line[i] = 0;
      recent_cell[i] = i;
    end
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part. The block first clears its store; a render right after
    // must come back as plain paper zero.
    offer_item(bavg_pkg::ACT_RENDER,    16'h0000, 8'h00, 8'd0,   6'd4);
    offer_item(bavg_pkg::ACT_BORDER,    16'hFFFF, 8'hFF, 8'd0,   6'd0);
    // Left border, right border, a group past the right border, and lines
    // below the picture.
    offer_item(bavg_pkg::ACT_RENDER,    16'h0000, 8'h00, 8'd0,   6'd0);
    offer_item(bavg_pkg::ACT_RENDER,    16'h0000, 8'h00, 8'd0,   6'd39);
    offer_item(bavg_pkg::ACT_RENDER,    16'h0000, 8'h00, 8'd0,   6'd63);
    offer_item(bavg_pkg::ACT_RENDER,    16'h0000, 8'h00, 8'd255, 6'd10);
    offer_item(bavg_pkg::ACT_RENDER,    16'h0000, 8'h00, 8'd192, 6'd20);
    // First bitmap byte and first attribute byte, with flash and bright set.
    offer_item(bavg_pkg::ACT_MEM_WRITE, 16'h4000, 8'hFF, 8'd0,   6'd0);
    offer_item(bavg_pkg::ACT_MEM_WRITE, 16'h5800, 8'hC7, 8'd0,   6'd0);
    offer_item(bavg_pkg::ACT_RENDER,    16'h0000, 8'h00, 8'd0,   6'd4);
    // Writes just outside the window and at the ends of the address space.
    offer_item(bavg_pkg::ACT_MEM_WRITE, 16'h3FFF, 8'h55, 8'd0,   6'd0);
    offer_item(bavg_pkg::ACT_MEM_WRITE, 16'h5B00, 8'h55, 8'd0,   6'd0);
    offer_item(bavg_pkg::ACT_MEM_WRITE, 16'hFFFF, 8'hAA, 8'd0,   6'd0);
    offer_item(bavg_pkg::ACT_MEM_WRITE, 16'h0000, 8'hAA, 8'd0,   6'd0);
    // Last bitmap byte and last attribute byte: bottom line, last cell.
    offer_item(bavg_pkg::ACT_MEM_WRITE, 16'h57FF, 8'hA5, 8'd0,   6'd0);
    offer_item(bavg_pkg::ACT_MEM_WRITE, 16'h5AFF, 8'h7A, 8'd0,   6'd0);
    offer_item(bavg_pkg::ACT_RENDER,    16'h0000, 8'h00, 8'd191, 6'd35);
    offer_item(bavg_pkg::ACT_FRAME_END, 16'h0000, 8'h00, 8'd0,   6'd0);
    offer_item(bavg_pkg::ACT_RENDER,    16'h0000, 8'h00, 8'd0,   6'd4);
    // Only the low three bits of a border write count.
    offer_item(bavg_pkg::ACT_BORDER,    16'h0000, 8'hF8, 8'd0,   6'd0);
    offer_item(bavg_pkg::ACT_RENDER,    16'h0000, 8'h00, 8'd100, 6'd3);
    offer_item(bavg_pkg::ACT_RENDER,    16'h0000, 8'h00, 8'd0,   6'd36);

    for (phase = 0; phase < 4; phase++) begin
      idle_pct  = idle_set[phase];
      stall_pct = stall_set[phase];
      for (n = 0; n < PHASE_ITEMS; n++) offer_random_item();
      if (phase == 0) begin
        // Back pressure: the receiver holds off while renders keep coming.
        holds_requested++;
        for (n = 0; n < PRESSURE_ITEMS; n++)
          offer_item(bavg_pkg::ACT_RENDER, 16'($urandom_range(16'hFFFF)),
                     8'($urandom_range(255)),
                     8'($urandom_range(bavg_pkg::SCREEN_LINES - 1)),
                     6'($urandom_range(4, 35)));
      end
    end

    @(negedge clk);
    item_valid <= 1'b0;
    idle_pct  = 0;
    stall_pct = 0;
    // Drain; the watchdog catches a result that never arrives.
    while (sb.expected_groups.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (sb.errors == 0) begin
      $display("** bitmap_attribute_video_generator_core: PASSED **");
    end else begin
      $display("** bitmap_attribute_video_generator_core: FAILED **");
    end
    $finish;
  end

endmodule

/* sim.f */
src/bavg_pkg.sv
src/bitmap_attribute_video_generator_core.sv
tb/testbench.sv
